FILE: design/sgr_pkg.sv
// Shared types, codes and constants for the SGR style decoder.
`default_nettype none

package sgr_pkg;

  // Upper bound on the parameter count of one sequence
  localparam int MAX_PARAMS = 16;

  localparam int PARAM_W = 16;
  localparam int LEFT_W  = 5;
  // Wide enough for both the count field and MAX_PARAMS itself
  localparam int CLAMP_W = ($clog2(MAX_PARAMS + 1) > LEFT_W) ?
                           $clog2(MAX_PARAMS + 1) : LEFT_W;

  localparam int COLOR_W = 24;
  localparam int FLAG_W  = 5;

  // Attribute flag bit positions
  localparam int FLAG_BOLD = 0;

  // SGR codes
  localparam logic [PARAM_W-1:0] CODE_RESET     = 16'd0;
  localparam logic [PARAM_W-1:0] CODE_BOLD      = 16'd1;
  localparam logic [PARAM_W-1:0] CODE_ITALIC    = 16'd3;
  localparam logic [PARAM_W-1:0] CODE_UNDERLINE = 16'd4;
  localparam logic [PARAM_W-1:0] CODE_INVERSE   = 16'd7;
  localparam logic [PARAM_W-1:0] CODE_STRIKE    = 16'd9;
  localparam logic [PARAM_W-1:0] CODE_NO_BOLD   = 16'd22;
  localparam logic [PARAM_W-1:0] CODE_NO_ITALIC = 16'd23;
  localparam logic [PARAM_W-1:0] CODE_NO_UNDER  = 16'd24;
  localparam logic [PARAM_W-1:0] CODE_NO_INV    = 16'd27;
  localparam logic [PARAM_W-1:0] CODE_NO_STRIKE = 16'd29;
  localparam logic [PARAM_W-1:0] CODE_FG_BASE   = 16'd30;
  localparam logic [PARAM_W-1:0] CODE_FG_EXT    = 16'd38;
  localparam logic [PARAM_W-1:0] CODE_FG_DEF    = 16'd39;
  localparam logic [PARAM_W-1:0] CODE_BG_BASE   = 16'd40;
  localparam logic [PARAM_W-1:0] CODE_BG_EXT    = 16'd48;
  localparam logic [PARAM_W-1:0] CODE_BG_DEF    = 16'd49;
  localparam logic [PARAM_W-1:0] CODE_FGB_BASE  = 16'd90;
  localparam logic [PARAM_W-1:0] CODE_BGB_BASE  = 16'd100;

  // Extended color selectors
  localparam logic [PARAM_W-1:0] SEL_INDEX = 16'd5;
  localparam logic [PARAM_W-1:0] SEL_RGB   = 16'd2;

  // Room left for an extended color, graded at the 38/48 code
  localparam logic [1:0] ROOM_NONE  = 2'd0;
  localparam logic [1:0] ROOM_INDEX = 2'd1;
  localparam logic [1:0] ROOM_RGB   = 2'd2;
  localparam int ROOM_INDEX_MIN = 3;
  localparam int ROOM_RGB_MIN   = 5;

  localparam logic [COLOR_W-1:0] FG_RESET_INDEX = 24'd7;
  localparam logic [COLOR_W-1:0] BG_RESET_INDEX = 24'd0;

  typedef struct packed {
    logic               is_rgb;
    logic               dflt;
    logic [COLOR_W-1:0] value;
  } color_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SELECT = 3'd1,
    PH_INDEX  = 3'd2,
    PH_RED    = 3'd3,
    PH_GREEN  = 3'd4,
    PH_BLUE   = 3'd5,
    PH_IGNORE = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_RESET,
    ACT_SET_FLAG,
    ACT_CLR_FLAG,
    ACT_FG_PAL,
    ACT_FG_DEF,
    ACT_BG_PAL,
    ACT_BG_DEF,
    ACT_FG_BRIGHT,
    ACT_BG_BRIGHT,
    ACT_EXT
  } act_kind_t;

  // Decoded meaning of one plain SGR code
  typedef struct packed {
    act_kind_t         kind;
    logic [FLAG_W-1:0] flag_mask;
    logic [2:0]        offset;
    logic              ext_bg;
  } code_action_t;

endpackage

`default_nettype wire

FILE: design/sgr_code_decode.sv
// Decoder from one plain SGR parameter to a style action.
`default_nettype none

module sgr_code_decode (
  input  logic [sgr_pkg::PARAM_W-1:0] param_value,
  output sgr_pkg::code_action_t       action
);
  import sgr_pkg::*;

  logic [PARAM_W-1:0] fg_off;
  logic [PARAM_W-1:0] bg_off;
  logic [PARAM_W-1:0] fgb_off;
  logic [PARAM_W-1:0] bgb_off;

  assign fg_off  = param_value - CODE_FG_BASE;
  assign bg_off  = param_value - CODE_BG_BASE;
  assign fgb_off = param_value - CODE_FGB_BASE;
  assign bgb_off = param_value - CODE_BGB_BASE;

  always_comb begin
    action           = '0;
    action.kind      = ACT_NONE;
    unique case (param_value) inside
      CODE_RESET: begin
        action.kind = ACT_RESET;
      end
      CODE_BOLD, CODE_ITALIC, CODE_UNDERLINE, CODE_INVERSE, CODE_STRIKE: begin
        action.kind = ACT_SET_FLAG;
      end
      CODE_NO_BOLD, CODE_NO_ITALIC, CODE_NO_UNDER, CODE_NO_INV, CODE_NO_STRIKE: begin
        action.kind = ACT_CLR_FLAG;
      end
      [CODE_FG_BASE : CODE_FG_BASE + 16'd7]: begin
        action.kind   = ACT_FG_PAL;
        action.offset = fg_off[2:0];
      end
      CODE_FG_DEF: begin
        action.kind = ACT_FG_DEF;
      end
      [CODE_BG_BASE : CODE_BG_BASE + 16'd7]: begin
        action.kind   = ACT_BG_PAL;
        action.offset = bg_off[2:0];
      end
      CODE_BG_DEF: begin
        action.kind = ACT_BG_DEF;
      end
      [CODE_FGB_BASE : CODE_FGB_BASE + 16'd7]: begin
        action.kind   = ACT_FG_BRIGHT;
        action.offset = fgb_off[2:0];
      end
      [CODE_BGB_BASE : CODE_BGB_BASE + 16'd7]: begin
        action.kind   = ACT_BG_BRIGHT;
        action.offset = bgb_off[2:0];
      end
      CODE_FG_EXT: begin
        action.kind = ACT_EXT;
      end
      CODE_BG_EXT: begin
        action.kind   = ACT_EXT;
        action.ext_bg = 1'b1;
      end
      default: begin
        action.kind = ACT_NONE;
      end
    endcase

    // Attribute bit touched by set/clear codes
    unique case (param_value)
      CODE_BOLD, CODE_NO_BOLD:        action.flag_mask = 5'b00001;
      CODE_ITALIC, CODE_NO_ITALIC:    action.flag_mask = 5'b00010;
      CODE_UNDERLINE, CODE_NO_UNDER:  action.flag_mask = 5'b00100;
      CODE_INVERSE, CODE_NO_INV:      action.flag_mask = 5'b01000;
      CODE_STRIKE, CODE_NO_STRIKE:    action.flag_mask = 5'b10000;
      default:                        action.flag_mask = 5'b00000;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/sgr_style_decoder.sv
// Top level of the SGR style decoder: style state, extended color phases, output register.
//
// The block keeps a terminal text style (bold, italic, underline, inverse,
// strikethrough, plus a foreground and a background color that are either a
// palette index or 24-bit RGB with a default mark) and updates it from the
// numeric parameters of Select Graphic Rendition sequences, one parameter per
// input transaction. Each input transaction carries the parameter and the
// count of parameters left in its sequence including this one; a count of 0
// stands for an empty sequence and resets the style. Every input transaction
// produces exactly one output transaction: the style after that parameter,
// with tlast set when the parameter closed its sequence (count 0 or 1).
// Extended colors 38/48;5;n and 38/48;2;r;g;b span several transactions
// through a small phase machine; a bad selector or too few parameters makes
// the rest of the sequence be ignored. Throughput is one transaction per
// clock while the sink keeps up: the whole update is one pass of decode logic
// into the style and output registers. tready drops only while the output
// register holds a transaction the sink has not taken.
`default_nettype none

module sgr_style_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] param_value, [20:16] params_left, [23:21] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] bold, [1] italic, [2] underline, [3] inverse, [4] strikethrough,
  // [28:5] fg_value, [29] fg_default, [53:30] bg_value, [54] bg_default, [55] zero
  output logic [55:0] m_axis_tdata,
  // [0] fg_is_rgb, [1] bg_is_rgb
  output logic [1:0]  m_axis_tuser,
  // sequence_done
  output logic        m_axis_tlast
);
  import sgr_pkg::*;

  localparam color_t FG_RESET = '{is_rgb: 1'b0, dflt: 1'b1, value: FG_RESET_INDEX};
  localparam color_t BG_RESET = '{is_rgb: 1'b0, dflt: 1'b1, value: BG_RESET_INDEX};

  // Style and extended color state
  logic [FLAG_W-1:0] flags, flags_next;
  color_t            fore, fore_next;
  color_t            back, back_next;
  phase_t            phase, phase_next;
  logic              ext_bg, ext_bg_next;
  logic [1:0]        room, room_next;
  logic [7:0]        red_hold, red_hold_next;
  logic [7:0]        green_hold, green_hold_next;

  logic [PARAM_W-1:0] param_value;
  logic [LEFT_W-1:0]  params_left;
  logic [CLAMP_W-1:0] left_wide;
  logic [CLAMP_W-1:0] left_eff;
  logic               seq_done;
  logic               seq_empty;
  logic               accept;
  code_action_t       action;
  color_t             ext_color;
  logic               ext_write;

  assign param_value = s_axis_tdata[PARAM_W-1:0];
  assign params_left = s_axis_tdata[PARAM_W +: LEFT_W];

  // Output register is the only buffer: accept whenever it is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Clamp oversized counts
  assign left_wide = CLAMP_W'(params_left);
  assign left_eff  = (left_wide > CLAMP_W'(MAX_PARAMS)) ? CLAMP_W'(MAX_PARAMS) : left_wide;
  assign seq_done  = left_eff <= CLAMP_W'(1);
  assign seq_empty = left_eff == '0;

  sgr_code_decode u_decode (
    .param_value (param_value),
    .action      (action)
  );

  // Phase machine: next state
  always_comb begin
    phase_next = phase;
    if (seq_empty) begin
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (action.kind == ACT_EXT) begin
            phase_next = PH_SELECT;
          end
        end
        PH_SELECT: begin
          if (param_value == SEL_INDEX && room != ROOM_NONE) begin
            phase_next = PH_INDEX;
          end else if (param_value == SEL_RGB && room == ROOM_RGB) begin
            phase_next = PH_RED;
          end else begin
            phase_next = PH_IGNORE;
          end
        end
        PH_INDEX:  phase_next = PH_IDLE;
        PH_RED:    phase_next = PH_GREEN;
        PH_GREEN:  phase_next = PH_BLUE;
        PH_BLUE:   phase_next = PH_IDLE;
        PH_IGNORE: phase_next = PH_IGNORE;
        default:   phase_next = PH_IDLE;
      endcase
    end
    // Any phase closes with its sequence; a cut-short color is dropped
    if (seq_done) begin
      phase_next = PH_IDLE;
    end
  end

  // Extended color that completes on this parameter, if any
  always_comb begin
    ext_write = 1'b0;
    ext_color = '0;
    if (!seq_empty && phase == PH_INDEX) begin
      ext_write       = 1'b1;
      ext_color.value = {16'd0, param_value[7:0]};
    end else if (!seq_empty && phase == PH_BLUE) begin
      ext_write        = 1'b1;
      ext_color.is_rgb = 1'b1;
      ext_color.value  = {red_hold, green_hold, param_value[7:0]};
    end
  end

  // Phase machine: style and hold updates
  always_comb begin
    flags_next      = flags;
    fore_next       = fore;
    back_next       = back;
    ext_bg_next     = ext_bg;
    room_next       = room;
    red_hold_next   = red_hold;
    green_hold_next = green_hold;

    if (seq_empty) begin
      flags_next = '0;
      fore_next  = FG_RESET;
      back_next  = BG_RESET;
    end else if (ext_write) begin
      if (ext_bg) begin
        back_next = ext_color;
      end else begin
        fore_next = ext_color;
      end
    end else if (phase == PH_RED) begin
      red_hold_next = param_value[7:0];
    end else if (phase == PH_GREEN) begin
      green_hold_next = param_value[7:0];
    end else if (phase == PH_IDLE) begin
      case (action.kind)
        ACT_RESET: begin
          flags_next = '0;
          fore_next  = FG_RESET;
          back_next  = BG_RESET;
        end
        ACT_SET_FLAG: flags_next = flags | action.flag_mask;
        ACT_CLR_FLAG: flags_next = flags & ~action.flag_mask;
        ACT_FG_PAL: begin
          // Bold lifts a normal foreground into the bright half
          fore_next = '{is_rgb: 1'b0, dflt: 1'b0,
                        value: {20'd0, flags[FLAG_BOLD], action.offset}};
        end
        ACT_FG_DEF: fore_next = FG_RESET;
        ACT_BG_PAL: begin
          back_next = '{is_rgb: 1'b0, dflt: 1'b0, value: {21'd0, action.offset}};
        end
        ACT_BG_DEF: back_next = BG_RESET;
        ACT_FG_BRIGHT: begin
          fore_next = '{is_rgb: 1'b0, dflt: 1'b1, value: {20'd0, 1'b1, action.offset}};
        end
        ACT_BG_BRIGHT: begin
          back_next = '{is_rgb: 1'b0, dflt: 1'b1, value: {20'd0, 1'b1, action.offset}};
        end
        ACT_EXT: begin
          ext_bg_next = action.ext_bg;
          if (left_eff >= CLAMP_W'(ROOM_RGB_MIN)) begin
            room_next = ROOM_RGB;
          end else if (left_eff >= CLAMP_W'(ROOM_INDEX_MIN)) begin
            room_next = ROOM_INDEX;
          end else begin
            room_next = ROOM_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      fore       <= FG_RESET;
      back       <= BG_RESET;
      phase      <= PH_IDLE;
      ext_bg     <= 1'b0;
      room       <= ROOM_NONE;
      red_hold   <= '0;
      green_hold <= '0;
    end else if (accept) begin
      flags      <= flags_next;
      fore       <= fore_next;
      back       <= back_next;
      phase      <= phase_next;
      ext_bg     <= ext_bg_next;
      room       <= room_next;
      red_hold   <= red_hold_next;
      green_hold <= green_hold_next;
    end
  end

  // Output register: valid flag under reset, payload loads on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {1'b0, back_next.dflt, back_next.value,
                       fore_next.dflt, fore_next.value, flags_next};
      m_axis_tuser <= {back_next.is_rgb, fore_next.is_rgb};
      m_axis_tlast <= seq_done;
    end
  end

endmodule

`default_nettype wire

FILE: design/sgr_checker.sv
// Port-level checker for the SGR style decoder, with its bind.
`default_nettype none

module sgr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // One result per parameter in the following cycle, tlast marking the sequence end
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_axis_tvalid
      && (m_axis_tlast == ($past(s_axis_tdata[20:16]) <= 5'd1)))
    else $error("missing result or wrong sequence end");

  // Never drop a pending result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // Empty sequence yields the reset style
  a_empty_reset: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_axis_tdata[20:16] == 5'd0 |=>
      m_axis_tdata == 56'h40_0000_2000_00E0 && m_axis_tuser == 2'b00)
    else $error("empty sequence did not reset the style");

  // A palette foreground never exceeds 8 bits
  a_fg_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[28:13] == 16'd0)
    else $error("palette index out of range");

endmodule

bind sgr_style_decoder sgr_checker u_sgr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: test/sgr_style_decoder_tb.sv
// Self-checking testbench for sgr_style_decoder: SGR parameter streams in, checked style stream out.
module sgr_style_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgr_pkg::*;

  // Cycles without any transaction before the run is declared hung
  localparam int IDLE_LIMIT = 2000;
  // Directed part plus about 500 random parameters
  localparam int PARAM_TARGET = 525;
  localparam int MAX_REPORTS = 10;

  // Style expected after one parameter
  typedef struct {
    logic [FLAG_W-1:0] flags;
    color_t            fore;
    color_t            back;
    logic              done;
  } style_beat_t;

  // Scoreboard: tracks the style the block should hold and compares every
  // output transaction against the oldest pending style.
  class style_scoreboard;
    logic [FLAG_W-1:0] flags;
    color_t            fore;
    color_t            back;
    phase_t            phase;
    logic              ext_bg;
    logic [1:0]        room;
    logic [7:0]        red;
    logic [7:0]        green;
    style_beat_t       pending_q[$];
    int                errors;
    int                checked;
    string             diffs;

    function new();
      errors  = 0;
      checked = 0;
      phase   = PH_IDLE;
      ext_bg  = 1'b0;
      room    = ROOM_NONE;
      red     = '0;
      green   = '0;
      clear_style();
    endfunction

    function color_t mk_color(logic rgb, logic dflt, logic [COLOR_W-1:0] value);
      color_t c;
      c.is_rgb = rgb;
      c.dflt   = dflt;
      c.value  = value;
      return c;
    endfunction

    function void clear_style();
      flags = '0;
      fore  = mk_color(1'b0, 1'b1, FG_RESET_INDEX);
      back  = mk_color(1'b0, 1'b1, BG_RESET_INDEX);
    endfunction

    // Extended colors always land with the default mark cleared
    function void load_ext(color_t c);
      if (ext_bg) back = c;
      else fore = c;
    endfunction

    function void plain_code(logic [PARAM_W-1:0] v, int left);
      logic [COLOR_W-1:0] bold_shift;
      bold_shift = flags[FLAG_BOLD] ? 24'd8 : 24'd0;
      if (v == CODE_RESET) clear_style();
      else if (v == CODE_BOLD) flags[0] = 1'b1;
      else if (v == CODE_ITALIC) flags[1] = 1'b1;
      else if (v == CODE_UNDERLINE) flags[2] = 1'b1;
      else if (v == CODE_INVERSE) flags[3] = 1'b1;
      else if (v == CODE_STRIKE) flags[4] = 1'b1;
      else if (v == CODE_NO_BOLD) flags[0] = 1'b0;
      else if (v == CODE_NO_ITALIC) flags[1] = 1'b0;
      else if (v == CODE_NO_UNDER) flags[2] = 1'b0;
      else if (v == CODE_NO_INV) flags[3] = 1'b0;
      else if (v == CODE_NO_STRIKE) flags[4] = 1'b0;
      else if (v >= CODE_FG_BASE && v <= CODE_FG_BASE + 7)
        fore = mk_color(1'b0, 1'b0, 24'(v - CODE_FG_BASE) + bold_shift);
      else if (v == CODE_FG_DEF) fore = mk_color(1'b0, 1'b1, FG_RESET_INDEX);
      else if (v >= CODE_BG_BASE && v <= CODE_BG_BASE + 7)
        back = mk_color(1'b0, 1'b0, 24'(v - CODE_BG_BASE));
      else if (v == CODE_BG_DEF) back = mk_color(1'b0, 1'b1, BG_RESET_INDEX);
      else if (v >= CODE_FGB_BASE && v <= CODE_FGB_BASE + 7)
        fore = mk_color(1'b0, 1'b1, 24'(v - CODE_FGB_BASE) + 24'd8);
      else if (v >= CODE_BGB_BASE && v <= CODE_BGB_BASE + 7)
        back = mk_color(1'b0, 1'b1, 24'(v - CODE_BGB_BASE) + 24'd8);
      else if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
        ext_bg = (v == CODE_BG_EXT);
        if (left >= ROOM_RGB_MIN) room = ROOM_RGB;
        else if (left >= ROOM_INDEX_MIN) room = ROOM_INDEX;
        else room = ROOM_NONE;
        phase = PH_SELECT;
      end
    endfunction

    // Advance the style by one accepted parameter and queue the result
    function void note_param(logic [PARAM_W-1:0] v, logic [LEFT_W-1:0] left_in);
      int          left;
      style_beat_t beat;
      left = (left_in > MAX_PARAMS) ? MAX_PARAMS : int'(left_in);
      if (left == 0) begin
        clear_style();
        phase = PH_IDLE;
      end else begin
        case (phase)
          PH_SELECT: begin
            if (v == SEL_INDEX && room != ROOM_NONE) phase = PH_INDEX;
            else if (v == SEL_RGB && room == ROOM_RGB) phase = PH_RED;
            else phase = PH_IGNORE;
          end
          PH_INDEX: begin
            load_ext(mk_color(1'b0, 1'b0, {16'h0000, v[7:0]}));
            phase = PH_IDLE;
          end
          PH_RED: begin
            red   = v[7:0];
            phase = PH_GREEN;
          end
          PH_GREEN: begin
            green = v[7:0];
            phase = PH_BLUE;
          end
          PH_BLUE: begin
            load_ext(mk_color(1'b1, 1'b0, {red, green, v[7:0]}));
            phase = PH_IDLE;
          end
          PH_IDLE: plain_code(v, left);
          default: ;
        endcase
      end
      if (left <= 1) phase = PH_IDLE;
      beat.flags = flags;
      beat.fore  = fore;
      beat.back  = back;
      beat.done  = (left <= 1);
      pending_q.push_back(beat);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void cmp(string name, logic [COLOR_W-1:0] e, logic [COLOR_W-1:0] a);
      if (e !== a) diffs = {diffs, " ", name};
    endfunction

    function void check_result(logic [55:0] data, logic [1:0] user, logic last);
      style_beat_t e;
      color_t      act_fg;
      color_t      act_bg;
      act_fg = {user[0], data[29], data[28:5]};
      act_bg = {user[1], data[54], data[53:30]};
      if (pending_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected style transaction: data=%h user=%b last=%b", data, user, last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      diffs = "";
      cmp("bold", 24'(e.flags[0]), 24'(data[0]));
      cmp("italic", 24'(e.flags[1]), 24'(data[1]));
      cmp("underline", 24'(e.flags[2]), 24'(data[2]));
      cmp("inverse", 24'(e.flags[3]), 24'(data[3]));
      cmp("strikethrough", 24'(e.flags[4]), 24'(data[4]));
      cmp("fg_is_rgb", 24'(e.fore.is_rgb), 24'(act_fg.is_rgb));
      cmp("fg_value", e.fore.value, act_fg.value);
      cmp("fg_default", 24'(e.fore.dflt), 24'(act_fg.dflt));
      cmp("bg_is_rgb", 24'(e.back.is_rgb), 24'(act_bg.is_rgb));
      cmp("bg_value", e.back.value, act_bg.value);
      cmp("bg_default", 24'(e.back.dflt), 24'(act_bg.dflt));
      cmp("pad", 24'd0, 24'(data[55]));
      cmp("sequence_done", 24'(e.done), 24'(last));
      if (diffs != "") begin
        if (errors < MAX_REPORTS)
          $display("style mismatch at result %0d:%s | exp flags=%b fg=%h bg=%h done=%b | got flags=%b fg=%h bg=%h done=%b",
                   checked, diffs, e.flags, e.fore, e.back, e.done,
                   data[4:0], act_fg, act_bg, last);
        errors++;
      end
      checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sgr_style_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  style_scoreboard style_sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: hold tready on a stall pattern whose mode and mask are redrawn together.
  // Mode 0 never stalls, mode 1 follows a rotating 16-bit mask (never all
  // zero), mode 2 flips a coin each cycle.
  int unsigned rx_cycle = 0;
  int          rx_mode = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 200 == 0) begin
      rx_mode    <= $urandom_range(0, 2);
      stall_mask <= 16'($urandom) | 16'h0001;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= stall_mask[rx_cycle % 16];
      default: m_axis_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Check every output transaction as the edge that moves it is seen
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      style_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog: end the run if neither side moves a transaction for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sgr_style_decoder_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Source side: bursts of random length separated by random gaps
  int burst_left = 0;
  int params_sent = 0;

  task automatic send_param(input logic [PARAM_W-1:0] v, input logic [LEFT_W-1:0] left);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      // Drop tvalid only when a real gap follows, so it never toggles within a step
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, left, v};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    style_sb.note_param(v, left);
    params_sent++;
  endtask

  // Parameters of the sequence under construction
  logic [PARAM_W-1:0] seq_q[$];

  // Send seq_q with counts falling from start_left, saturating at zero.
  // A start equal to the length gives a well-formed sequence.
  task automatic send_seq(input int start_left);
    int left;
    foreach (seq_q[i]) begin
      left = start_left - i;
      if (left < 0) left = 0;
      send_param(seq_q[i], LEFT_W'(left));
    end
    seq_q.delete();
  endtask

  function automatic logic [PARAM_W-1:0] pick_ext();
    return ($urandom_range(0, 1) == 1) ? CODE_BG_EXT : CODE_FG_EXT;
  endfunction

  // Append one SGR element (a plain code or a whole extended color)
  function automatic void add_element();
    logic [PARAM_W-1:0] set_codes[5];
    logic [PARAM_W-1:0] clr_codes[5];
    set_codes = '{CODE_BOLD, CODE_ITALIC, CODE_UNDERLINE, CODE_INVERSE, CODE_STRIKE};
    clr_codes = '{CODE_NO_BOLD, CODE_NO_ITALIC, CODE_NO_UNDER, CODE_NO_INV, CODE_NO_STRIKE};
    case ($urandom_range(0, 11))
      0: seq_q.push_back(CODE_RESET);
      1: seq_q.push_back(set_codes[$urandom_range(0, 4)]);
      2: seq_q.push_back(clr_codes[$urandom_range(0, 4)]);
      3: seq_q.push_back(CODE_FG_BASE + PARAM_W'($urandom_range(0, 7)));
      4: seq_q.push_back(CODE_BG_BASE + PARAM_W'($urandom_range(0, 7)));
      5: seq_q.push_back(CODE_FGB_BASE + PARAM_W'($urandom_range(0, 7)));
      6: seq_q.push_back(CODE_BGB_BASE + PARAM_W'($urandom_range(0, 7)));
      7: seq_q.push_back(($urandom_range(0, 1) == 1) ? CODE_BG_DEF : CODE_FG_DEF);
      8: begin
        // 38/48;5;n with n over the full 16 bits
        seq_q.push_back(pick_ext());
        seq_q.push_back(SEL_INDEX);
        seq_q.push_back(PARAM_W'($urandom));
      end
      9: begin
        // 38/48;2;r;g;b
        seq_q.push_back(pick_ext());
        seq_q.push_back(SEL_RGB);
        repeat (3) seq_q.push_back(PARAM_W'($urandom));
      end
      10: begin
        // Random selector, often bad, then some trailing parameters skipped after a bad one
        seq_q.push_back(pick_ext());
        seq_q.push_back(($urandom_range(0, 1) == 1) ? PARAM_W'($urandom_range(0, 8))
                                                     : PARAM_W'($urandom));
        repeat ($urandom_range(0, 3)) seq_q.push_back(PARAM_W'($urandom_range(0, 110)));
      end
      default: seq_q.push_back(($urandom_range(0, 1) == 1) ? PARAM_W'($urandom_range(0, 127))
                                                            : PARAM_W'($urandom));
    endcase
  endfunction

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty sequence with an all-ones value
    seq_q = '{16'hFFFF};
    send_seq(0);
    // Every attribute on, then the top fg palette code shifted by bold
    seq_q = '{CODE_BOLD, CODE_ITALIC, CODE_UNDERLINE, CODE_INVERSE, CODE_STRIKE,
              CODE_FG_BASE + 16'd7};
    send_seq(6);
    // Bold off, bright colors at their top codes, then reset
    seq_q = '{CODE_NO_BOLD, CODE_FGB_BASE + 16'd7, CODE_BGB_BASE + 16'd7, CODE_RESET};
    send_seq(4);
    // Indexed fg with the count at its maximum (clamped) and a truncated index
    seq_q = '{CODE_FG_EXT, SEL_INDEX, 16'hFFFF};
    send_seq(31);
    // RGB bg with components given over 16 bits, two of them above 8 bits
    seq_q = '{CODE_BG_EXT, SEL_RGB, 16'h01AB, 16'hFFCD, 16'h00EF};
    send_seq(5);
    // RGB asked with room for an index only: rest ignored
    seq_q = '{CODE_FG_EXT, SEL_RGB, CODE_BOLD};
    send_seq(3);
    // Index asked with no room: cut short at the end of the sequence
    seq_q = '{CODE_BG_EXT, SEL_INDEX};
    send_seq(2);

    while (params_sent < PARAM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          // Noise: any value with any count
          seq_q.push_back(PARAM_W'($urandom));
          send_seq($urandom_range(0, 31));
        end
        1: begin
          seq_q.push_back(PARAM_W'($urandom));
          send_seq(0);
        end
        2: begin
          // Well-formed content with inconsistent counts
          repeat ($urandom_range(1, 4)) add_element();
          send_seq($urandom_range(0, 31));
        end
        default: begin
          // Mostly short sequences; now and then one above MAX_PARAMS
          if ($urandom_range(0, 14) == 0) begin
            target = $urandom_range(MAX_PARAMS + 1, 31);
            while (seq_q.size() < target) add_element();
            while (seq_q.size() > 31) void'(seq_q.pop_back());
          end else begin
            repeat ($urandom_range(1, 5)) add_element();
          end
          send_seq(seq_q.size());
        end
      endcase
    end

    // Stop sending, drain the output side, then wait for any strays before reporting
    s_axis_tvalid <= 1'b0;
    while (style_sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (style_sb.errors == 0) begin
      $display("sgr_style_decoder_tb: done, clean");
    end else begin
      $display("sgr_style_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sgr_pkg.sv
design/sgr_code_decode.sv
design/sgr_style_decoder.sv
design/sgr_checker.sv
test/sgr_style_decoder_tb.sv
